// ===== design/vm_memory_fetch_and_frame_stack_assert.svh =====
// Assertion macros used by the design file vm_memory_fetch_and_frame_stack.sv.
`ifndef VM_MEMORY_FETCH_AND_FRAME_STACK_ASSERT_SVH
`define VM_MEMORY_FETCH_AND_FRAME_STACK_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VMFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define VMFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vmfs_pkg.sv =====
package vmfs_pkg;

  // Sizes
  localparam int ADDR_BITS   = 16;
  localparam int STACK_DEPTH = 1024;
  localparam int SP_BITS     = $clog2(STACK_DEPTH);

  // Saved-frame mark written when no frame exists
  localparam logic [63:0] NO_FRAME_MARK = 64'h0000_0000_FFFF_FFFF;

  // Action codes
  localparam logic [2:0] ACT_WRITE  = 3'd0;
  localparam logic [2:0] ACT_READ   = 3'd1;
  localparam logic [2:0] ACT_FETCH  = 3'd2;
  localparam logic [2:0] ACT_PUSH   = 3'd3;
  localparam logic [2:0] ACT_POP    = 3'd4;
  localparam logic [2:0] ACT_ENTER  = 3'd5;
  localparam logic [2:0] ACT_EXIT   = 3'd6;
  localparam logic [2:0] ACT_SET_PC = 3'd7;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NOFRAME = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  byte_in;
    logic [1:0]  fetch_width;
    logic [63:0] push_value;
  } in_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic [1:0]  status;
    logic [15:0] pc_out;
  } out_t;

endpackage

// ===== design/vm_memory_fetch_and_frame_stack.sv =====
// Memory block of a small virtual machine: byte memory, program counter,
// 64-bit value stack and frame pointer.
// Input channel in_valid/in_ready carries one action per beat; the result
// channel out_valid/out_ready returns exactly one beat per input beat, with
// the read, fetched or popped value, a status code and the new pc.
// One item is worked at a time; in_ready is high only while the sequencer
// is idle. Each item runs S_EXEC, then S_RESP; some add a state between:
//   write, push, enter, set pc, and any error case: none
//   read, pop, exit: S_WAIT (one registered read of a single-port memory)
//   fetch of n bytes: S_FETCH (the byte memory has one port, one byte a cycle)
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, the finished item after that one holds in
// the sequencer until the output register frees.
// Reset (rst_n low, synchronous) clears pc, stack and frame pointers and
// drops any result pending. Memory contents are not cleared; reading a byte
// or stack slot never written returns arbitrary data.
`include "vm_memory_fetch_and_frame_stack_assert.svh"

module vm_memory_fetch_and_frame_stack (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vmfs_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output vmfs_pkg::out_t out_data
);
  import vmfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_WAIT,
    S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  in_t                  item_r, item_nxt;
  logic [ADDR_BITS-1:0] pc_r, pc_nxt;
  logic [SP_BITS-1:0]   top_r, top_nxt;
  logic                 empty_r, empty_nxt;
  logic [SP_BITS-1:0]   fbase_r, fbase_nxt;
  logic                 fabsent_r, fabsent_nxt;
  logic [63:0]          data_r, data_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [ADDR_BITS-1:0] ptr_r, ptr_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  logic                 mem_we, mem_re;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           mem_rdata;
  logic                 stk_we, stk_re;
  logic [SP_BITS-1:0]   stk_addr;
  logic [63:0]          stk_wdata, stk_rdata;

  logic                 full;
  logic [SP_BITS-1:0]   new_top;
  logic [3:0]           nbytes;

  vmfs_ram #(.WIDTH(8), .AW(ADDR_BITS)) u_byte_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (item_r.byte_in),
    .rdata (mem_rdata)
  );

  vmfs_ram #(.WIDTH(64), .AW(SP_BITS)) u_stack_mem (
    .clk   (clk),
    .we    (stk_we),
    .re    (stk_re),
    .addr  (stk_addr),
    .wdata (stk_wdata),
    .rdata (stk_rdata)
  );

  assign full    = !empty_r && (top_r == SP_BITS'(STACK_DEPTH - 1));
  assign new_top = empty_r ? '0 : top_r + SP_BITS'(1);
  assign nbytes  = 4'd1 << item_r.fetch_width;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    pc_nxt        = pc_r;
    top_nxt       = top_r;
    empty_nxt     = empty_r;
    fbase_nxt     = fbase_r;
    fabsent_nxt   = fabsent_r;
    data_nxt      = data_r;
    status_nxt    = status_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = ADDR_BITS'(item_r.address);
    stk_we        = 1'b0;
    stk_re        = 1'b0;
    stk_addr      = top_r;
    stk_wdata     = item_r.push_value;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        data_nxt   = '0;
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
        case (item_r.action)
          ACT_WRITE: begin
            mem_we = 1'b1;
          end
          ACT_READ: begin
            mem_re    = 1'b1;
            state_nxt = S_WAIT;
          end
          ACT_FETCH: begin
            ptr_nxt   = pc_r;
            cnt_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_FETCH;
          end
          ACT_PUSH: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              stk_we    = 1'b1;
              stk_addr  = new_top;
              top_nxt   = new_top;
              empty_nxt = 1'b0;
            end
          end
          ACT_POP: begin
            if (empty_r) begin
              status_nxt = ST_EMPTY;
            end else begin
              stk_re    = 1'b1;
              state_nxt = S_WAIT;
            end
          end
          ACT_ENTER: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              stk_we      = 1'b1;
              stk_addr    = new_top;
              stk_wdata   = fabsent_r ? NO_FRAME_MARK : 64'(fbase_r);
              top_nxt     = new_top;
              empty_nxt   = 1'b0;
              fbase_nxt   = new_top;
              fabsent_nxt = 1'b0;
            end
          end
          ACT_EXIT: begin
            if (fabsent_r) begin
              status_nxt = ST_NOFRAME;
            end else begin
              stk_re    = 1'b1;
              stk_addr  = fbase_r;
              state_nxt = S_WAIT;
            end
          end
          default: begin
            pc_nxt = ADDR_BITS'(item_r.address);
          end
        endcase
      end

      // Issue one byte read a cycle, shift in the byte read last cycle
      S_FETCH: begin
        if (pend_r) begin
          data_nxt = {data_r[55:0], mem_rdata};
        end
        if (cnt_r != nbytes) begin
          mem_re   = 1'b1;
          mem_addr = ptr_r;
          ptr_nxt  = ptr_r + ADDR_BITS'(1);
          cnt_nxt  = cnt_r + 4'd1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          pc_nxt    = ptr_r;
          state_nxt = S_RESP;
        end
      end

      // Take registered memory data
      S_WAIT: begin
        state_nxt = S_RESP;
        case (item_r.action)
          ACT_READ: begin
            data_nxt = {56'd0, mem_rdata};
          end
          ACT_POP: begin
            data_nxt = stk_rdata;
            if (top_r == '0) begin
              empty_nxt = 1'b1;
            end else begin
              top_nxt = top_r - SP_BITS'(1);
            end
          end
          default: begin
            // Frame exit: cut back to the frame slot and pop it
            if (fbase_r == '0) begin
              top_nxt   = '0;
              empty_nxt = 1'b1;
            end else begin
              top_nxt   = fbase_r - SP_BITS'(1);
              empty_nxt = 1'b0;
            end
            if (|stk_rdata[63:SP_BITS]) begin
              fabsent_nxt = 1'b1;
              fbase_nxt   = '0;
            end else begin
              fabsent_nxt = 1'b0;
              fbase_nxt   = stk_rdata[SP_BITS-1:0];
            end
          end
        endcase
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.data_out = data_r;
          out_nxt.status   = status_r;
          out_nxt.pc_out   = 16'(pc_r);
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      top_r       <= '0;
      empty_r     <= 1'b1;
      fbase_r     <= '0;
      fabsent_r   <= 1'b1;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      top_r       <= top_nxt;
      empty_r     <= empty_nxt;
      fbase_r     <= fbase_nxt;
      fabsent_r   <= fabsent_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r   <= item_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
    ptr_r    <= ptr_nxt;
    out_r    <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `VMFS_ASSERT_NOW(a_empty_top, empty_r, top_r == '0, "empty stack with nonzero top")
  `VMFS_ASSERT_NOW(a_absent_base, fabsent_r, fbase_r == '0, "no frame with nonzero base")
  `VMFS_ASSERT_NOW(a_fetch_cnt, state_r == S_FETCH, cnt_r <= 4'd8, "fetch count overrun")
  `VMFS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

endmodule

// ===== design/vmfs_ram.sv =====
module vmfs_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [(1 << AW)];

  // Single port: write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
